// ===== rtl/core/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted list with trim of both ends.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

	// Default capacity of the sorted store
	localparam int SLT_DEPTH = 16;

	// Entry width and result count width
	localparam int VAL_W = 32;
	localparam int CNT_OUT_W = 5;

	// Fewest entries for which a trim keeps anything
	localparam int TRIM_MIN = 3;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TRIM   = 1'b1;

	// Status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Request transaction
	typedef struct packed {
		logic                    command;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_OUT_W-1:0]    count;
		logic signed [VAL_W-1:0] smallest;
		logic signed [VAL_W-1:0] largest;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/slt_cmp.sv =====
// ----------------------------------------------------------------------------
// slt_cmp
// Signed compare unit: flags a new value below a stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cmp
	import slt_pkg::*;
(
	input  wire logic signed [VAL_W-1:0] a,
	input  wire logic signed [VAL_W-1:0] b,
	output logic                         lt
);

	// Signed less-than, the only comparison the sequencer needs
	assign lt = (a < b);

endmodule

`default_nettype wire

// ===== rtl/core/slt_seq.sv =====
// ----------------------------------------------------------------------------
// slt_seq
// Sequencer and entry memory: inserts by shifting entries up from the top,
// trims by shifting entries down one slot, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_seq
	import slt_pkg::*;
#(
	parameter int DEPTH = SLT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      idle,
	output logic      res_valid,
	input  wire logic res_ready,
	output rsp_t      res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_TRM,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           ptr_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] min_q;
	logic signed [VAL_W-1:0] max_q;
	logic [1:0]              status_q;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_q;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [VAL_W-1:0] wdata;
	logic [AW-1:0]           raddr;

	logic                    lt;
	logic                    ptr_at_top;
	logic                    ptr_at_last;

	slt_cmp u_cmp (
		.a  (value_q),
		.b  (rd_q),
		.lt (lt)
	);

	assign ptr_at_top  = (CW'(ptr_q) == cnt_q);
	assign ptr_at_last = (CW'(ptr_q) == (cnt_q - CW'(TRIM_MIN)));

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Drive memory ports from the sequencer state
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rd_q;
		raddr = AW'(ptr_q - AW'(2));
		case (state_q)
			S_IDLE: begin
				waddr = '0;
				wdata = req.value;
				if (req.command == CMD_INSERT) begin
					raddr = AW'(cnt_q - CW'(1));
					we    = start && (cnt_q == '0);
				end else begin
					raddr = AW'(1);
				end
			end
			S_INS: begin
				we = 1'b1;
				if ((ptr_q == '0) || !lt) begin
					wdata = value_q;
				end
			end
			S_TRM: begin
				we    = 1'b1;
				raddr = AW'(ptr_q + AW'(2));
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequence the insert and trim passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			status_q <= STATUS_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						value_q  <= req.value;
						status_q <= STATUS_OK;
						state_q  <= S_DONE;
						if (req.command == CMD_INSERT) begin
							if (cnt_q == CW'(DEPTH)) begin
								status_q <= STATUS_FULL;
							end else if (cnt_q == '0) begin
								min_q <= req.value;
								max_q <= req.value;
								cnt_q <= CW'(1);
							end else begin
								ptr_q   <= AW'(cnt_q);
								state_q <= S_INS;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= STATUS_EMPTY;
							end else if (cnt_q < CW'(TRIM_MIN)) begin
								cnt_q <= '0;
							end else begin
								ptr_q   <= '0;
								state_q <= S_TRM;
							end
						end
					end
				end
				S_INS: begin
					// Place the value, or move the entry below up one slot
					if ((ptr_q == '0) || !lt) begin
						if (ptr_q == '0) begin
							min_q <= value_q;
						end
						if (ptr_at_top) begin
							max_q <= value_q;
						end
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_TRM: begin
					// Move the entry above down one slot
					if (ptr_q == '0) begin
						min_q <= rd_q;
					end
					if (ptr_at_last) begin
						max_q   <= rd_q;
						cnt_q   <= cnt_q - CW'(2);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Present the result while done
	assign idle         = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res.status   = status_q;
	assign res.count    = CNT_OUT_W'(cnt_q);
	assign res.smallest = (cnt_q == '0) ? '0 : min_q;
	assign res.largest  = (cnt_q == '0) ? '0 : max_q;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_trim_ends.sv =====
// ----------------------------------------------------------------------------
// sorted_list_trim_ends
// Ascending sorted store of signed values with insert and trim of both ends.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req) carries a command and a value.
//   An insert places the value after equal entries; a trim removes the
//   smallest and largest entries. Each request yields one response
//   transaction (rsp_valid/rsp_ready/rsp) with status, count, smallest and
//   largest value.
//   An insert shifts entries up until its slot is found; a trim of three or
//   more entries shifts the remaining entries down. Full, empty and short
//   cases need no shift pass. The single memory port pair moves one entry
//   per cycle, so the shift pass sets the rate; the worst case is an insert
//   at the front of DEPTH-1 entries.
//   req_ready is high only while the sequencer is idle.
//   Reset clears the count; entries are written before they are ever read.
//   A response waits in the output register while rsp_ready is low; the
//   next request may be accepted meanwhile and completes once the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_trim_ends
	import slt_pkg::*;
#(
	parameter int DEPTH = SLT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic start;
	logic idle;
	logic res_valid;
	logic res_ready;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign req_ready = idle;
	assign start     = req_valid && req_ready;
	assign res_ready = !rsp_valid_q || rsp_ready;

	slt_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Hold the response until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer goes busy after every accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req_ready)
		else $error("request accepted but sequencer did not go busy");

	// A dropped insert reports a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_FULL) |-> (rsp.count == CNT_OUT_W'(DEPTH)))
		else $error("full status with a count other than capacity");

	// Ends of a nonempty store are ordered
	a_ends_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.count != '0) |-> (rsp.smallest <= rsp.largest))
		else $error("smallest above largest");

	// Empty store reports zero ends
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.count == '0) |-> (rsp.smallest == '0) && (rsp.largest == '0))
		else $error("empty store with nonzero ends");

endmodule

`default_nettype wire
